// ===== sv/mlfc_pkg.sv =====
// shared types and constants of the meter line frame checker
`default_nettype none

package mlfc_pkg;

  // line store geometry
  localparam int unsigned MaxLine    = 63;
  localparam int unsigned StoreDepth = 64;
  localparam int unsigned AddrW      = 6;
  localparam int unsigned CountW     = 7;
  localparam int unsigned CharW      = 7;
  localparam int unsigned SumW       = 6;
  localparam int unsigned MinLenW    = 6;
  localparam int unsigned RxW        = 8;

  // checksum bias added to the 6-bit sum
  localparam logic [CharW-1:0] ChecksumBias = 7'h20;

  // configuration register indexes and reset values
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;
  localparam logic [CfgIdxW-1:0] CfgStartChar = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEndChar   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinLength = 2'd2;

  localparam logic [CharW-1:0]   StartCharRst = 7'd10;
  localparam logic [CharW-1:0]   EndCharRst   = 7'd13;
  localparam logic [MinLenW-1:0] MinLengthRst = 6'd4;

  // configuration seen by the checker
  typedef struct packed {
    logic [CharW-1:0]   start_char;
    logic [CharW-1:0]   end_char;
    logic [MinLenW-1:0] min_length;
  } cfg_t;

  // line store access request
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [CharW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== sv/mlfc_if.sv =====
// input and output channel interfaces of the meter line frame checker
`default_nettype none

interface mlfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mlfc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] line_byte;
  logic       line_last;

  modport source (output valid, output line_byte, output line_last, input ready);
  modport sink (input valid, input line_byte, input line_last, output ready);
endinterface

`default_nettype wire

// ===== sv/mlfc_store.sv =====
// line store memory with one write port and one registered read port
`default_nettype none

module mlfc_store import mlfc_pkg::*; (
  input  wire logic             clk_i,
  input  wire mem_req_t         req_i,
  output logic      [CharW-1:0] rd_data_o
);

  logic [CharW-1:0] mem [StoreDepth];
  logic [CharW-1:0] rd_data_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== sv/mlfc_ctrl.sv =====
// line collector, checksum test and replay sequencer
`default_nettype none

module mlfc_ctrl import mlfc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cfg_t         cfg_i,
  mlfc_in_if.sink           in_ch,
  mlfc_out_if.source        out_ch
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StLoad = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [CharW-1:0]    prev_q, prev_d;
  logic                out_valid_q, out_valid_d;
  logic [AddrW-1:0]    idx_q, idx_d;
  logic [AddrW-1:0]    len_q, len_d;
  logic [CharW-1:0]    out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;

  mem_req_t            mem_req;
  logic [CharW-1:0]    rd_data;

  logic [CharW-1:0]    rx_char;
  logic                in_fire;
  logic                out_free;
  logic                is_start;
  logic                is_end;
  logic                in_range;
  logic                sum_ok;
  logic                at_last;

  mlfc_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // handshake and decode
  assign in_ch.ready = (state_q == StIdle);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_q || out_ch.ready;
  assign rx_char     = in_ch.rx_byte[CharW-1:0];
  assign is_start    = (rx_char == cfg_i.start_char);
  assign is_end      = !is_start && (rx_char == cfg_i.end_char);
  assign in_range    = (count_q != '0)
                    && ((count_q + CountW'(1)) >= {1'b0, cfg_i.min_length})
                    && (count_q <= CountW'(MaxLine - 1));
  assign sum_ok      = (({1'b0, sum_q} + ChecksumBias) == prev_q);
  assign at_last     = (idx_q == (len_q - AddrW'(1)));

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sum_d       = sum_q;
    prev_d      = prev_q;
    idx_d       = idx_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    mem_req     = '0;
    mem_req.waddr = count_q[AddrW-1:0];
    mem_req.wdata = rx_char;
    mem_req.raddr = idx_q + AddrW'(1);

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (is_start) begin
            count_d = '0;
            sum_d   = '0;
            prev_d  = '0;
          end else if (is_end) begin
            if (in_range) begin
              if (sum_ok) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = '0;
                idx_d         = '0;
                len_d         = count_q[AddrW-1:0];
                state_d       = StLoad;
              end
              count_d = '0;
              sum_d   = '0;
              prev_d  = '0;
            end
          end else if (count_q <= CountW'(MaxLine)) begin
            mem_req.we = 1'b1;
            if (count_q != '0) begin
              sum_d = sum_q + prev_q[SumW-1:0];
            end
            prev_d  = rx_char;
            count_d = count_q + CountW'(1);
          end else begin
            count_d = '0;
            sum_d   = '0;
            prev_d  = '0;
          end
        end
      end
      StLoad: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = rd_data;
          out_last_d  = at_last;
          if (at_last) begin
            state_d = StIdle;
          end else begin
            mem_req.re = 1'b1;
            idx_d      = idx_q + AddrW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      sum_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  // replay index and output word
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    len_q      <= len_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.line_byte = out_byte_q;
  assign out_ch.line_last = out_last_q;

`ifndef SYNTHESIS
  // byte count never runs past one over the line limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxLine + 1))
    else $error("byte count beyond line limit");

  // replay index stays inside the replayed line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad) |-> (len_q != '0) && (idx_q < len_q))
    else $error("replay index outside line");

  // loading the last word ends the replay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad) && out_free && at_last |=> (state_q == StIdle) && out_last_q)
    else $error("replay did not end on last word");

  // a passing end character starts a replay with a cleared line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_end && in_range && sum_ok |=> (state_q == StLoad) && (count_q == '0))
    else $error("valid line did not start replay");
`endif

endmodule

`default_nettype wire

// ===== sv/meter_line_frame_checker.sv =====
// top level of the meter line frame checker: configuration registers and checker
//
//  channel   direction  payload                     accepted when
//  in_ch     in         rx_byte[7:0]                valid && ready
//  out_ch    out        line_byte[6:0], line_last   valid && ready
//  cfg       in         cfg_idx_i, cfg_data_i       cfg_we_i
//
// ready stays high between lines; a received byte is taken whenever it is valid.
// a passing end character starts a replay of n stored words through the
// registered read port of the line store, one per cycle unless stalled.
// ready is low during the replay; a stalled output holds the replay in place.
// the output register lets the next byte be taken while the last word waits.
// reset clears count, sum, prev byte; config takes defaults; store not cleared.
`default_nettype none

module meter_line_frame_checker import mlfc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  mlfc_in_if.sink                  in_ch,
  mlfc_out_if.source               out_ch
);

  cfg_t cfg_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_char <= StartCharRst;
      cfg_q.end_char   <= EndCharRst;
      cfg_q.min_length <= MinLengthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStartChar: cfg_q.start_char <= cfg_data_i[CharW-1:0];
        CfgEndChar:   cfg_q.end_char   <= cfg_data_i[CharW-1:0];
        CfgMinLength: cfg_q.min_length <= cfg_data_i[MinLenW-1:0];
        default: begin
        end
      endcase
    end
  end

  mlfc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
